FILE: hw/rtl/ising_lattice_spin_update_assert.svh
// assertion macros shared by the spin update block
`ifndef ISING_LATTICE_SPIN_UPDATE_ASSERT_SVH
`define ISING_LATTICE_SPIN_UPDATE_ASSERT_SVH

// same-cycle implication
`define ILS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ils_pkg.sv
// types, codes and constants of the spin update block
package ils_pkg;

  localparam int MaxSideDefault = 64;

  localparam logic [1:0] OpLoad   = 2'd0;
  localparam logic [1:0] OpUpdate = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;

  localparam logic [1:0] CfgCoupling = 2'd0;
  localparam logic [1:0] CfgBias     = 2'd1;
  localparam logic [1:0] CfgSide     = 2'd2;

  localparam logic [15:0] CouplingReset = 16'd4096;
  localparam logic [15:0] BiasReset     = 16'd0;
  localparam logic [6:0]  SideReset     = 7'd64;

  localparam logic [3:0] ExpLastStep = 4'd15;

  typedef enum logic [1:0] {
    NbMid,
    NbUp,
    NbDn
  } nb_sel_e;

  typedef enum logic [2:0] {
    StIdle,
    StRdMid,
    StRdUp,
    StRdDn,
    StCapDn,
    StCalc,
    StExp,
    StDone
  } ils_state_e;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    nb_sel_e rd_sel;
    logic    cap_en;
    nb_sel_e cap_sel;
    logic    calc;
    logic    exp_en;
    logic    finish;
  } ils_cmd_t;

  typedef struct packed {
    logic exp_last;
    logic out_free;
  } ils_sts_t;

  // round(2^32 * exp(-2^(k-12)))
  function automatic logic [31:0] exp_factor(logic [3:0] k);
    logic [31:0] f;
    unique case (k)
      4'd0:  f = 32'd4293918848;
      4'd1:  f = 32'd4292870656;
      4'd2:  f = 32'd4290775039;
      4'd3:  f = 32'd4286586875;
      4'd4:  f = 32'd4278222805;
      4'd5:  f = 32'd4261543595;
      4'd6:  f = 32'd4228380000;
      4'd7:  f = 32'd4162825044;
      4'd8:  f = 32'd4034748382;
      4'd9:  f = 32'd3790295335;
      4'd10: f = 32'd3344923893;
      4'd11: f = 32'd2605029347;
      4'd12: f = 32'd1580030169;
      4'd13: f = 32'd581260615;
      4'd14: f = 32'd78665070;
      default: f = 32'd1440801;
    endcase
    return f;
  endfunction

endpackage

FILE: hw/rtl/ising_lattice_spin_update.sv
// top level of the ising lattice metropolis spin update block
//
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   operation, row, col, load_spin, uniform_draw
// out      output     out_valid_o / out_ready_i out_row, out_col, spin_after, flipped
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index, cfg_data
//
// one request at a time: an accept state, three row reads of the lattice ram and one
// capture state, one energy step, sixteen steps of the shared exponent multiplier and a
// write-back state; a new request is taken only after the last one is written back
// lattice rows carry valid flags cleared at reset, so no clearing pass is run
// a result held by out_ready_i low stalls the write-back until the slot frees
// configuration writes are taken in every cycle
module ising_lattice_spin_update #(
  parameter int MAX_SIDE = ils_pkg::MaxSideDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [5:0]  row_i,
  input  logic [5:0]  col_i,
  input  logic        load_spin_i,
  input  logic [15:0] uniform_draw_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  out_row_o,
  output logic [5:0]  out_col_o,
  output logic        spin_after_o,
  output logic        flipped_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import ils_pkg::*;

  ils_cmd_t cmd;
  ils_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ils_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ils_datapath #(
    .MAX_SIDE(MAX_SIDE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .row_i         (row_i),
    .col_i         (col_i),
    .load_spin_i   (load_spin_i),
    .uniform_draw_i(uniform_draw_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_row_o     (out_row_o),
    .out_col_o     (out_col_o),
    .spin_after_o  (spin_after_o),
    .flipped_o     (flipped_o)
  );

endmodule

FILE: hw/rtl/ils_ram.sv
// generic single-port-write ram with registered read
module ils_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/ils_ctrl.sv
// sequencing state machine of the spin update block
`include "ising_lattice_spin_update_assert.svh"
module ils_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ils_pkg::ils_sts_t sts_i,
  output ils_pkg::ils_cmd_t cmd_o
);
  import ils_pkg::*;

  ils_state_e state_q, state_d;
  ils_cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    cmd.rd_sel  = NbMid;
    cmd.cap_sel = NbMid;
    in_ready_o  = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.latch = 1'b1;
          state_d   = StRdMid;
        end
      end
      StRdMid: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = NbMid;
        state_d    = StRdUp;
      end
      StRdUp: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = NbUp;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = NbMid;
        state_d     = StRdDn;
      end
      StRdDn: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = NbDn;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = NbUp;
        state_d     = StCapDn;
      end
      StCapDn: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = NbDn;
        state_d     = StCalc;
      end
      StCalc: begin
        cmd.calc = 1'b1;
        state_d  = StExp;
      end
      StExp: begin
        cmd.exp_en = 1'b1;
        if (sts_i.exp_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd.finish = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign cmd_o = cmd;

  `ILS_ASSERT_IMPL(a_finish_free, cmd.finish, sts_i.out_free, "result written over pending one")
  `ILS_ASSERT_NEXT(a_exp_end, (state_q == StExp) && sts_i.exp_last, state_q == StDone,
                   "exponent pass did not end")

endmodule

FILE: hw/rtl/ils_datapath.sv
// lattice store, energy change, exponent unit and result register
`include "ising_lattice_spin_update_assert.svh"
module ils_datapath #(
  parameter int MAX_SIDE = ils_pkg::MaxSideDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ils_pkg::ils_cmd_t cmd_i,
  output ils_pkg::ils_sts_t sts_o,
  input  logic [1:0]        operation_i,
  input  logic [5:0]        row_i,
  input  logic [5:0]        col_i,
  input  logic              load_spin_i,
  input  logic [15:0]       uniform_draw_i,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [5:0]        out_row_o,
  output logic [5:0]        out_col_o,
  output logic              spin_after_o,
  output logic              flipped_o
);
  import ils_pkg::*;

  localparam int AW = $clog2(MAX_SIDE);
  localparam logic [8:0] MaxSideW = 9'(MAX_SIDE);

  logic [1:0]  op_q;
  logic [5:0]  row_q, col_q;
  logic        ld_q;
  logic [15:0] draw_q;
  logic signed [15:0] coupling_q, bias_q;
  logic [6:0]  side_q;

  logic [MAX_SIDE-1:0] row_vld_q;
  logic                rd_vld_q;
  logic [MAX_SIDE-1:0] mid_q, up_q, dn_q;
  logic [MAX_SIDE-1:0] rdata, cap_row, wdata;

  logic        delta_neg_q, m_big_q;
  logic [15:0] m_q;
  logic [32:0] acc_q;
  logic [3:0]  k_q;

  logic        out_valid_q;
  logic [5:0]  out_row_q, out_col_q;
  logic        spin_q, flip_q;

  logic [8:0]    n_side, row9, col9, row9_p1, col9_p1;
  logic          in_range, has_up, has_dn, has_lt, has_rt;
  logic [AW-1:0] row_a, up_a, dn_a, col_a, lt_a, rt_a, raddr;
  logic          s_bit;
  logic signed [3:0]  t_up, t_dn, t_lt, t_rt, nsum;
  logic signed [19:0] cpl_x, nsum_x, bias_x, cn, h;
  logic signed [21:0] h2, delta, mag;
  logic [64:0] prod, prod_r;
  logic [32:0] rnd;
  logic [16:0] prob;
  logic        flip, new_bit, we;

  // site geometry
  assign n_side  = ({2'b0, side_q} < MaxSideW) ? {2'b0, side_q} : MaxSideW;
  assign row9    = {3'b0, row_q};
  assign col9    = {3'b0, col_q};
  assign row9_p1 = row9 + 9'd1;
  assign col9_p1 = col9 + 9'd1;
  assign in_range = (row9 < n_side) && (col9 < n_side);
  assign has_up  = (row_q != 6'd0);
  assign has_dn  = (row9_p1 < n_side);
  assign has_lt  = (col_q != 6'd0);
  assign has_rt  = (col9_p1 < n_side);
  assign row_a   = AW'(row9);
  assign up_a    = AW'(row9 - 9'd1);
  assign dn_a    = AW'(row9_p1);
  assign col_a   = AW'(col9);
  assign lt_a    = AW'(col9 - 9'd1);
  assign rt_a    = AW'(col9_p1);

  always_comb begin
    unique case (cmd_i.rd_sel)
      NbUp:    raddr = up_a;
      NbDn:    raddr = dn_a;
      default: raddr = row_a;
    endcase
  end

  ils_ram #(
    .WIDTH(MAX_SIDE),
    .DEPTH(MAX_SIDE)
  ) u_lattice (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(row_a),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // rows never written read as all minus one
  assign cap_row = rd_vld_q ? rdata : '0;

  // energy change
  assign s_bit = mid_q[col_a];
  assign t_up  = !has_up ? 4'sd0 : (up_q[col_a] ? 4'sd1 : -4'sd1);
  assign t_dn  = !has_dn ? 4'sd0 : (dn_q[col_a] ? 4'sd1 : -4'sd1);
  assign t_lt  = !has_lt ? 4'sd0 : (mid_q[lt_a] ? 4'sd1 : -4'sd1);
  assign t_rt  = !has_rt ? 4'sd0 : (mid_q[rt_a] ? 4'sd1 : -4'sd1);
  assign nsum  = t_up + t_dn + t_lt + t_rt;
  assign cpl_x  = {{4{coupling_q[15]}}, coupling_q};
  assign bias_x = {{4{bias_q[15]}}, bias_q};
  assign nsum_x = {{16{nsum[3]}}, nsum};
  assign cn     = cpl_x * nsum_x;
  assign h      = bias_x + cn;
  assign h2     = {h[19], h, 1'b0};
  assign delta  = s_bit ? -h2 : h2;
  assign mag    = -delta;

  // one exponent factor per step
  assign prod   = {32'b0, acc_q} * {33'b0, exp_factor(k_q)};
  assign prod_r = prod + 65'h0_8000_0000;

  assign rnd  = acc_q + 33'h0_0000_8000;
  assign prob = !delta_neg_q ? 17'h10000 : (m_big_q ? 17'h0 : rnd[32:16]);
  assign flip = (op_q == OpUpdate) && in_range && ({1'b0, draw_q} < prob);
  assign new_bit = (op_q == OpLoad) ? ld_q : (s_bit ^ flip);
  assign we = cmd_i.finish && in_range && ((op_q == OpLoad) || flip);

  always_comb begin
    wdata        = mid_q;
    wdata[col_a] = new_bit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coupling_q  <= CouplingReset;
      bias_q      <= BiasReset;
      side_q      <= SideReset;
      row_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgCoupling: coupling_q <= cfg_data_i;
          CfgBias:     bias_q     <= cfg_data_i;
          CfgSide:     side_q     <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (we) begin
        row_vld_q[row_a] <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= operation_i;
      row_q  <= row_i;
      col_q  <= col_i;
      ld_q   <= load_spin_i;
      draw_q <= uniform_draw_i;
    end
    if (cmd_i.rd_en) begin
      rd_vld_q <= row_vld_q[raddr];
    end
    if (cmd_i.cap_en) begin
      unique case (cmd_i.cap_sel)
        NbUp:    up_q  <= cap_row;
        NbDn:    dn_q  <= cap_row;
        default: mid_q <= cap_row;
      endcase
    end
    if (cmd_i.calc) begin
      delta_neg_q <= delta[21];
      m_big_q     <= (mag[21:16] != 6'd0);
      m_q         <= mag[15:0];
      acc_q       <= 33'h1_0000_0000;
      k_q         <= 4'd0;
    end else if (cmd_i.exp_en) begin
      if (m_q[k_q]) begin
        acc_q <= prod_r[64:32];
      end
      k_q <= k_q + 4'd1;
    end
    if (cmd_i.finish) begin
      out_row_q <= row_q;
      out_col_q <= col_q;
      spin_q    <= in_range ? new_bit : 1'b0;
      flip_q    <= flip;
    end
  end

  assign sts_o.exp_last = (k_q == ExpLastStep);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign spin_after_o = spin_q;
  assign flipped_o    = flip_q;

  `ILS_ASSERT_IMPL(a_we_range, we, in_range, "lattice write outside side")
  `ILS_ASSERT_IMPL(a_we_flip, we && (op_q != OpLoad), flip, "update wrote without flip")

endmodule

FILE: dv/ising_lattice_spin_update_tb.sv
// self-checking testbench of the ising lattice metropolis spin update block
`timescale 1ns / 1ps

module ising_lattice_spin_update_tb;
  import ils_pkg::*;

  localparam int Side = 64;
  localparam int CycleLimit = 2_000_000;
  localparam logic [1:0] OpSpare = 2'd3;

  typedef struct packed {
    logic [5:0] row;
    logic [5:0] col;
    logic       spin;
    logic       flip;
  } site_res_t;

  typedef struct {
    logic [1:0]  op;
    logic [5:0]  row;
    logic [5:0]  col;
    logic        ld;
    logic [15:0] draw;
    logic        known;
    site_res_t   res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [5:0]  row_i;
  logic [5:0]  col_i;
  logic        load_spin_i;
  logic [15:0] uniform_draw_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [5:0]  out_row_o;
  logic [5:0]  out_col_o;
  logic        spin_after_o;
  logic        flipped_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  ising_lattice_spin_update DUT (.*);

  logic        spins [Side*Side];
  logic signed [15:0] coupling_q;
  logic signed [15:0] bias_q;
  logic [6:0]  side_q;

  site_res_t   pending_sites[$];
  int          errors;
  int          n_sent;
  int          n_checked;
  int          n_flips;
  int          cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;

  function automatic logic [15:0] exp_prob(logic [31:0] m);
    logic [63:0] acc;
    logic [31:0] fac [16] = '{32'd4293918848, 32'd4292870656, 32'd4290775039,
      32'd4286586875, 32'd4278222805, 32'd4261543595, 32'd4228380000,
      32'd4162825044, 32'd4034748382, 32'd3790295335, 32'd3344923893,
      32'd2605029347, 32'd1580030169, 32'd581260615, 32'd78665070, 32'd1440801};
    acc = 64'd1 << 32;
    if (m >= 32'd65536) return 16'd0;
    for (int k = 0; k < 16; k++)
      if (m[k]) acc = (acc * 64'(fac[k]) + (64'd1 << 31)) >> 32;
    acc = (acc + 64'd32768) >> 16;
    return acc[15:0];
  endfunction

  function automatic int spin_of(int r, int c);
    return spins[r*Side + c] ? 1 : -1;
  endfunction

  function automatic site_res_t apply_site_op(logic [1:0] op, logic [5:0] r, logic [5:0] c,
                                              logic ld, logic [15:0] draw);
    site_res_t res;
    int n;
    int s;
    int nsum;
    int h;
    int delta;
    int prob;
    n = (side_q < Side) ? int'(side_q) : Side;
    res = '{row: r, col: c, spin: 1'b0, flip: 1'b0};
    if (r < n && c < n) begin
      if (op == OpLoad) begin
        spins[r*Side + c] = ld;
      end else if (op == OpUpdate) begin
        s = spin_of(r, c);
        nsum = 0;
        if (r > 0) nsum += spin_of(r - 1, c);
        if (r + 1 < n) nsum += spin_of(r + 1, c);
        if (c > 0) nsum += spin_of(r, c - 1);
        if (c + 1 < n) nsum += spin_of(r, c + 1);
        h = int'(bias_q) + int'(coupling_q) * nsum;
        delta = -2 * s * h;
        prob = (delta >= 0) ? 65536 : int'(exp_prob(32'(-delta)));
        if (int'(draw) < prob) begin
          spins[r*Side + c] = ~spins[r*Side + c];
          res.flip = 1'b1;
        end
      end
      res.spin = spins[r*Side + c];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
    errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    site_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_sites.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_sites.pop_front();
        if (out_row_o !== want.row) report_mismatch("out_row", out_row_o, want.row);
        if (out_col_o !== want.col) report_mismatch("out_col", out_col_o, want.col);
        if (spin_after_o !== want.spin) report_mismatch("spin_after", spin_after_o, want.spin);
        if (flipped_o !== want.flip) report_mismatch("flipped", flipped_o, want.flip);
        n_flips += want.flip;
      end
      n_checked++;
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_request(logic [1:0] op, logic [5:0] r, logic [5:0] c, logic ld,
                              logic [15:0] draw, logic known, site_res_t want);
    site_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    row_i          <= r;
    col_i          <= c;
    load_spin_i    <= ld;
    uniform_draw_i <= draw;
    do @(posedge clk_i); while (!in_ready_o);
    res = apply_site_op(op, r, c, ld, draw);
    if (known && res !== want) report_mismatch("table row", res, want);
    pending_sites.push_back(res);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_sites.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgCoupling: coupling_q = val;
      CfgBias:     bias_q = val;
      CfgSide:     side_q = val[6:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic random_phase(int count, int sidx, int ridx);
    logic [1:0] op;
    logic [5:0] r;
    logic [5:0] c;
    int lim;
    send_idle_pct  = sidx;
    recv_stall_pct = ridx;
    lim = (side_q < Side) ? int'(side_q) : Side;
    if (lim < 1) lim = 1;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2: op = OpLoad;
        9:       op = $urandom_range(1) ? OpRead : OpSpare;
        default: op = OpUpdate;
      endcase
      if ($urandom_range(9) == 0) begin
        r = 6'($urandom);
        c = 6'($urandom);
      end else begin
        r = 6'($urandom_range(lim > 8 ? 7 : lim - 1));
        c = 6'($urandom_range(lim > 8 ? 7 : lim - 1));
      end
      send_request(op, r, c, 1'($urandom), 16'($urandom), 1'b0, '0);
    end
  endtask

  stim_row_t dir_rows[$];

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = OpLoad;
    row_i          = '0;
    col_i          = '0;
    load_spin_i    = 1'b0;
    uniform_draw_i = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CfgCoupling;
    cfg_data_i     = '0;
    hold_off       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    errors = 0; n_sent = 0; n_checked = 0; n_flips = 0; cycles = 0;
    foreach (spins[i]) spins[i] = 1'b0;
    coupling_q = CouplingReset;
    bias_q     = BiasReset;
    side_q     = SideReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset, corners, op three, a flip and the flip back
    dir_rows = '{
      '{OpRead,   6'd0,  6'd0,  1'b0, 16'h0000, 1'b1, '{6'd0, 6'd0, 1'b0, 1'b0}},
      '{OpRead,   6'd63, 6'd63, 1'b0, 16'h0000, 1'b1, '{6'd63, 6'd63, 1'b0, 1'b0}},
      '{OpLoad,   6'd63, 6'd0,  1'b1, 16'hffff, 1'b1, '{6'd63, 6'd0, 1'b1, 1'b0}},
      '{OpSpare,  6'd63, 6'd0,  1'b0, 16'h0000, 1'b1, '{6'd63, 6'd0, 1'b1, 1'b0}},
      '{OpUpdate, 6'd10, 6'd10, 1'b0, 16'h0000, 1'b1, '{6'd10, 6'd10, 1'b1, 1'b1}},
      '{OpUpdate, 6'd10, 6'd10, 1'b0, 16'hffff, 1'b1, '{6'd10, 6'd10, 1'b0, 1'b1}},
      '{OpUpdate, 6'd20, 6'd20, 1'b0, 16'h0000, 1'b0, '0},
      '{OpUpdate, 6'd0,  6'd63, 1'b0, 16'h0001, 1'b0, '0},
      '{OpLoad,   6'd0,  6'd1,  1'b1, 16'h0000, 1'b1, '{6'd0, 6'd1, 1'b1, 1'b0}},
      '{OpUpdate, 6'd0,  6'd0,  1'b0, 16'h8000, 1'b0, '0},
      '{OpUpdate, 6'd63, 6'd63, 1'b0, 16'hffff, 1'b0, '0},
      '{OpLoad,   6'd0,  6'd0,  1'b0, 16'h0000, 1'b1, '{6'd0, 6'd0, 1'b0, 1'b0}}
    };
    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].row, dir_rows[i].col, dir_rows[i].ld,
                   dir_rows[i].draw, dir_rows[i].known, dir_rows[i].res);
    wait_drained();

    write_reg(CfgSide, 16'd2);
    write_reg(CfgCoupling, 16'h7fff);
    write_reg(CfgBias, 16'h8000);
    send_request(OpLoad, 6'd2, 6'd0, 1'b1, 16'h0, 1'b1, '{6'd2, 6'd0, 1'b0, 1'b0});
    send_request(OpUpdate, 6'd5, 6'd1, 1'b0, 16'h0, 1'b1, '{6'd5, 6'd1, 1'b0, 1'b0});
    for (int i = 0; i < 6; i++)
      send_request(OpUpdate, 6'(i[0]), 6'(i[1]), 1'b0, 16'($urandom), 1'b0, '0);
    random_phase(60, 0, 0);
    wait_drained();

    write_reg(CfgSide, 16'd5);
    write_reg(CfgCoupling, 16'h0400);
    write_reg(CfgBias, 16'h0200);
    random_phase(130, 87, 0);
    wait_drained();

    write_reg(CfgSide, 16'd7);
    write_reg(CfgCoupling, 16'h8000);
    write_reg(CfgBias, 16'h7fff);
    random_phase(130, 0, 87);
    wait_drained();

    write_reg(CfgSide, 16'd127);
    write_reg(CfgCoupling, 16'hf000);
    write_reg(CfgBias, 16'hfc00);
    random_phase(120, 24, 24);
    wait_drained();

    write_reg(CfgSide, 16'd1);
    write_reg(CfgCoupling, 16'h1000);
    write_reg(CfgBias, 16'h0000);
    random_phase(20, 0, 0);
    wait_drained();
    write_reg(CfgSide, 16'd0);
    random_phase(10, 0, 0);
    wait_drained();

    // long hold-off on the receiver so the block backs up
    write_reg(CfgSide, 16'd6);
    write_reg(CfgCoupling, 16'h0800);
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(40, 0, 0);
    join
    wait_drained();
    random_phase(120, 0, 0);
    wait_drained();

    $display("%0d requests sent, %0d results checked, %0d flips, seven register settings",
             n_sent, n_checked, n_flips);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
